FILE: src/psa_pkg.sv
// Shared types and constants for the priority scheduler with aging.
package psa_pkg;

  localparam int PRIO_W = 16;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [2:0] EV_CREATED  = 3'd0;
  localparam logic [2:0] EV_FULL     = 3'd1;
  localparam logic [2:0] EV_IDLE     = 3'd2;
  localparam logic [2:0] EV_RAN      = 3'd3;
  localparam logic [2:0] EV_FINISHED = 3'd4;
  localparam logic [2:0] EV_BLOCKED  = 3'd5;

  localparam logic REG_AGING_STEP  = 1'b0;
  localparam logic REG_RUN_PENALTY = 1'b1;

  typedef struct packed {
    logic         cmd;
    logic [9:0]   start_priority;
    logic [7:0]   need_time;
    logic [7:0]   run_burst;
    logic [7:0]   block_time;
  } req_t;

  typedef struct packed {
    logic [2:0]         slot_index;
    logic [2:0]         event_res;
    logic signed [15:0] priority_now;
    logic [3:0]         woken_count;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the request
    logic scan_clr;  // start a selection scan
    logic scan_step; // compare one slot
    logic apply;     // commit the create or tick
  } psa_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;
  } psa_sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    else if (v < -18'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

endpackage

FILE: src/psa_if.sv
// Valid/ready channel interface carrying one payload.
interface psa_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/psa_ctrl.sv
// Controller state machine for the scheduler.
module psa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output psa_pkg::psa_cmd_t  cmd,
  input  psa_pkg::psa_sts_t  sts
);
  import psa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_OUT = 2'd3;

  logic [1:0] state, state_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end
endmodule

FILE: src/psa_dp.sv
// Datapath: slot table, selection scan and tick update.
module psa_dp #(
  parameter int SLOTS = 8,
  parameter int TIME_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  psa_pkg::req_t     req,
  input  psa_pkg::psa_cmd_t cmd,
  output psa_pkg::psa_sts_t sts,
  output psa_pkg::rsp_t     rsp
);
  import psa_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  logic [3:0] aging_step, run_penalty;
  logic [SLOTS-1:0] slot_used, slot_blocked;
  logic signed [PRIO_W-1:0] prio [SLOTS];
  logic [TIME_BITS-1:0] t_need [SLOTS], t_used [SLOTS];
  logic [TIME_BITS-1:0] b_rel [SLOTS], b_left [SLOTS];
  logic [TIME_BITS-1:0] k_rel [SLOTS], k_left [SLOTS];
  logic cur_valid;
  logic [SW-1:0] cur_slot;

  req_t r;
  logic [SW-1:0] idx;
  // Best ready, best blocked, first free, found flags.
  logic rdy_f, blk_f, free_f;
  logic [SW-1:0] rdy_s, blk_s, free_s;

  assign sts.scan_last = (idx == SW'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      aging_step <= 4'd1;
      run_penalty <= 4'd3;
    end else if (cfg_we) begin
      if (cfg_index == REG_AGING_STEP) aging_step <= cfg_data;
      else run_penalty <= cfg_data;
    end
  end

  // Scan: one slot per cycle, strict greater keeps the lowest slot on ties.
  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
    if (cmd.scan_clr) begin
      idx <= '0;
      rdy_f <= 1'b0;
      blk_f <= 1'b0;
      free_f <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!sts.scan_last) idx <= idx + 1'b1;
      if (!slot_used[idx]) begin
        if (!free_f) begin
          free_f <= 1'b1;
          free_s <= idx;
        end
      end else if (!slot_blocked[idx]) begin
        if (!rdy_f || prio[idx] > prio[rdy_s]) begin
          rdy_f <= 1'b1;
          rdy_s <= idx;
        end
      end else begin
        if (!blk_f || prio[idx] > prio[blk_s]) begin
          blk_f <= 1'b1;
          blk_s <= idx;
        end
      end
    end
  end

  // Tick update, computed for every slot in parallel.
  logic run_ok;
  logic [SW-1:0] rs;
  logic [SLOTS-1:0] blk_mid;
  logic signed [PRIO_W-1:0] p_run;
  logic [TIME_BITS-1:0] u_run, bl_run;
  logic [3:0] woken;
  logic fin, blk_now;

  always_comb begin
    run_ok = cur_valid || rdy_f || blk_f;
    rs = cur_valid ? cur_slot : (rdy_f ? rdy_s : blk_s);
    blk_mid = slot_blocked;
    if (!cur_valid && !rdy_f && blk_f) blk_mid[blk_s] = 1'b0;
    p_run = sat16(18'(prio[rs]) - 18'(run_penalty));
    u_run = (t_used[rs] < TMAX) ? t_used[rs] + 1'b1 : t_used[rs];
    bl_run = (b_left[rs] != '0) ? b_left[rs] - 1'b1 : b_left[rs];
    woken = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && blk_mid[i] && k_left[i] <= TIME_BITS'(1))
        woken = woken + 4'd1;
    end
    fin = (u_run >= t_need[rs]);
    blk_now = !fin && (bl_run == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      slot_blocked <= '0;
      cur_valid <= 1'b0;
      cur_slot <= '0;
    end else if (cmd.apply) begin
      if (r.cmd == CMD_CREATE) begin
        if (free_f) begin
          slot_used[free_s] <= 1'b1;
          slot_blocked[free_s] <= 1'b0;
        end
      end else if (run_ok) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && blk_mid[i] && k_left[i] <= TIME_BITS'(1))
            slot_blocked[i] <= 1'b0;
          else slot_blocked[i] <= blk_mid[i];
        end
        if (fin) begin
          slot_used[rs] <= 1'b0;
          slot_blocked[rs] <= 1'b0;
          cur_valid <= 1'b0;
        end else if (blk_now) begin
          slot_blocked[rs] <= 1'b1;
          cur_valid <= 1'b0;
        end else begin
          cur_valid <= 1'b1;
        end
        cur_slot <= rs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (r.cmd == CMD_CREATE) begin
        if (free_f) begin
          prio[free_s] <= PRIO_W'(r.start_priority);
          t_need[free_s] <= TIME_BITS'(r.need_time);
          t_used[free_s] <= '0;
          b_rel[free_s] <= TIME_BITS'(r.run_burst);
          b_left[free_s] <= TIME_BITS'(r.run_burst);
          k_rel[free_s] <= TIME_BITS'(r.block_time);
          k_left[free_s] <= TIME_BITS'(r.block_time);
          rsp <= '{slot_index: 3'(free_s), event_res: EV_CREATED,
                   priority_now: PRIO_W'(r.start_priority), woken_count: 4'd0};
        end else begin
          rsp <= '{slot_index: 3'd0, event_res: EV_FULL,
                   priority_now: '0, woken_count: 4'd0};
        end
      end else if (!run_ok) begin
        rsp <= '{slot_index: 3'd0, event_res: EV_IDLE,
                 priority_now: '0, woken_count: 4'd0};
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && !blk_mid[i] && SW'(i) != rs)
            prio[i] <= sat16(18'(prio[i]) + 18'(aging_step));
          if (slot_used[i] && blk_mid[i]) begin
            if (k_left[i] <= TIME_BITS'(1)) k_left[i] <= k_rel[i];
            else k_left[i] <= k_left[i] - 1'b1;
          end
        end
        prio[rs] <= p_run;
        t_used[rs] <= u_run;
        b_left[rs] <= blk_now ? b_rel[rs] : bl_run;
        rsp <= '{slot_index: 3'(rs),
                 event_res: fin ? EV_FINISHED : (blk_now ? EV_BLOCKED : EV_RAN),
                 priority_now: p_run, woken_count: woken};
      end
    end
  end
endmodule

FILE: src/priority_scheduler_with_aging.sv
// Top level of the priority scheduler with aging.
// Each transaction is accepted in the idle state and then passes a scan of
// one slot per cycle, an update state and a state with the result on the
// port. A new transaction is taken only after the result has been taken;
// the slot scan sets the throughput.
// Synchronous active-high reset empties the table and restores the
// configuration registers to aging step 1 and run penalty 3.
module priority_scheduler_with_aging #(
  parameter int SLOTS = 8,
  parameter int TIME_BITS = 8
) (
  input logic       clk,
  input logic       rst,
  psa_if.sink       in_ch,
  psa_if.source     out_ch,
  input logic       cfg_we,
  input logic [0:0] cfg_index,
  input logic [3:0] cfg_data
);
  import psa_pkg::*;

  psa_cmd_t cmd;
  psa_sts_t sts;

  // The controller sequences capture, scan, update and result handoff.
  psa_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  // The datapath holds the slot table and the result register.
  psa_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .req(in_ch.data), .cmd, .sts, .rsp(out_ch.data)
  );
endmodule

FILE: src/psa_checker.sv
// Port-level checker for the scheduler, bound to the top level.
module psa_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input psa_pkg::rsp_t out_data
);
  import psa_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.event_res <= EV_BLOCKED) else $error("bad event");
  a_woken_only_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_res == EV_CREATED || out_data.event_res == EV_FULL
      || out_data.event_res == EV_IDLE) |-> out_data.woken_count == 4'd0)
    else $error("wake on non-run result");
endmodule

bind priority_scheduler_with_aging psa_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

FILE: tb/priority_scheduler_with_aging_tb.sv
// Self-checking testbench for the priority scheduler with aging.
`timescale 1ns / 1ps
module priority_scheduler_with_aging_tb;
  import psa_pkg::*;

  localparam int NSLOT = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  always #2 clk = ~clk;

  psa_if #(.T(req_t)) in_ch (.clk(clk));
  psa_if #(.T(rsp_t)) out_ch (.clk(clk));

  priority_scheduler_with_aging i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the scheduler state used to predict each result.
  logic               sh_used [NSLOT];
  logic               sh_blocked [NSLOT];
  logic signed [15:0] sh_prio [NSLOT];
  logic [7:0]         sh_need [NSLOT];
  logic [7:0]         sh_spent [NSLOT];
  logic [7:0]         sh_burst_rl [NSLOT];
  logic [7:0]         sh_burst [NSLOT];
  logic [7:0]         sh_block_rl [NSLOT];
  logic [7:0]         sh_block [NSLOT];
  logic               sh_cur_valid;
  int                 sh_cur;
  logic [3:0]         sh_aging;
  logic [3:0]         sh_penalty;

  rsp_t expected_events[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   idle_cycles = 0;
  bit   no_idle = 1'b0;
  int   creates_sent = 0;
  int   ticks_sent = 0;

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Highest priority slot in the wanted blocked state; ties go to the lowest slot.
  function automatic int best_slot(logic want_blocked);
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (sh_used[i] && sh_blocked[i] == want_blocked)
        if (best < 0 || sh_prio[i] > sh_prio[best]) best = i;
    return best;
  endfunction

  function automatic rsp_t schedule_step(req_t rq);
    rsp_t r;
    int s;
    int woken;
    r = '0;
    if (rq.cmd == CMD_CREATE) begin
      s = -1;
      for (int i = 0; i < NSLOT; i++)
        if (!sh_used[i] && s < 0) s = i;
      if (s < 0) begin
        r.event_res = EV_FULL;
        return r;
      end
      sh_used[s] = 1'b1;
      sh_blocked[s] = 1'b0;
      sh_prio[s] = {6'd0, rq.start_priority};
      sh_need[s] = rq.need_time;
      sh_spent[s] = 8'd0;
      sh_burst_rl[s] = rq.run_burst;
      sh_burst[s] = rq.run_burst;
      sh_block_rl[s] = rq.block_time;
      sh_block[s] = rq.block_time;
      r.slot_index = s[2:0];
      r.event_res = EV_CREATED;
      r.priority_now = sh_prio[s];
      return r;
    end
    if (!sh_cur_valid) begin
      s = best_slot(1'b0);
      if (s < 0) begin
        s = best_slot(1'b1);
        if (s < 0) begin
          r.event_res = EV_IDLE;
          return r;
        end
        // A blocked process is taken as it stands, its countdown untouched.
        sh_blocked[s] = 1'b0;
      end
      sh_cur_valid = 1'b1;
      sh_cur = s;
    end
    s = sh_cur;
    sh_prio[s] = clamp16(int'(sh_prio[s]) - int'(sh_penalty));
    if (sh_spent[s] != 8'hff) sh_spent[s]++;
    if (sh_burst[s] != 0) sh_burst[s]--;
    for (int i = 0; i < NSLOT; i++)
      if (i != s && sh_used[i] && !sh_blocked[i])
        sh_prio[i] = clamp16(int'(sh_prio[i]) + int'(sh_aging));
    // Wake-ups come after aging, so the newly woken get no aging this tick.
    woken = 0;
    for (int i = 0; i < NSLOT; i++)
      if (sh_used[i] && sh_blocked[i]) begin
        if (sh_block[i] != 0) sh_block[i]--;
        if (sh_block[i] == 0) begin
          sh_blocked[i] = 1'b0;
          sh_block[i] = sh_block_rl[i];
          woken++;
        end
      end
    r.event_res = EV_RAN;
    if (sh_spent[s] >= sh_need[s]) begin
      // Finishing wins over blocking in the same tick.
      r.event_res = EV_FINISHED;
      sh_used[s] = 1'b0;
      sh_blocked[s] = 1'b0;
      sh_cur_valid = 1'b0;
    end else if (sh_burst[s] == 0) begin
      r.event_res = EV_BLOCKED;
      sh_blocked[s] = 1'b1;
      sh_burst[s] = sh_burst_rl[s];
      sh_cur_valid = 1'b0;
    end
    r.slot_index = s[2:0];
    r.priority_now = sh_prio[s];
    r.woken_count = woken[3:0];
    return r;
  endfunction

  // Sends one transaction, with a random gap before it in some cycles.
  // Valid stays up after acceptance until the next transaction or a drain
  // replaces it at the following falling edge.
  task automatic send_item(req_t rq);
    while (!no_idle && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.data <= rq;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_events.push_back(schedule_step(rq));
    if (rq.cmd == CMD_TICK) ticks_sent++;
    else creates_sent++;
    @(negedge clk);
  endtask

  task automatic send_create(int pr, int nt, int rb, int bt);
    req_t rq;
    rq.cmd = CMD_CREATE;
    rq.start_priority = pr[9:0];
    rq.need_time = nt[7:0];
    rq.run_burst = rb[7:0];
    rq.block_time = bt[7:0];
    send_item(rq);
  endtask

  task automatic send_tick();
    req_t rq;
    rq.cmd = CMD_TICK;
    rq.start_priority = 10'($urandom);
    rq.need_time = 8'($urandom);
    rq.run_burst = 8'($urandom);
    rq.block_time = 8'($urandom);
    send_item(rq);
  endtask

  // Waits until every result is in, plus a margin; used before a register write and at the end.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [3:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_AGING_STEP) sh_aging = val;
    else sh_penalty = val;
  endtask

  // Random output stalls; the checker samples at the rising edge.
  always @(negedge clk)
    out_ch.ready <= rst ? 1'b0 : (no_idle || $urandom_range(99) >= 9);

  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
        end else begin
          exp_r = expected_events.pop_front();
          if (out_ch.data !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected slot %0d ev %0d prio %0d woken %0d, got %0d %0d %0d %0d",
                exp_r.slot_index, exp_r.event_res, exp_r.priority_now, exp_r.woken_count,
                out_ch.data.slot_index, out_ch.data.event_res, out_ch.data.priority_now,
                out_ch.data.woken_count);
          end
        end
      end
    end
  end

  always @(posedge clk)
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end

  // Empty table, full table and idle ticks, with the field extremes.
  task automatic test_directed();
    send_tick();
    send_create(1023, 255, 255, 255);
    send_create(0, 1, 1, 1);
    send_create(0, 0, 0, 0);
    send_create(500, 3, 1, 2);
    send_create(500, 6, 2, 1);
    send_create(1, 2, 255, 1);
    send_create(1023, 1, 1, 255);
    send_create(700, 4, 1, 3);
    send_create(300, 5, 5, 5);
    send_create(0, 255, 255, 255);
    repeat (14) send_tick();
  endtask

  // Short-lived processes so the table keeps turning over.
  task automatic test_random_mix(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 40)
        send_create($urandom_range(1023), $urandom_range(12), $urandom_range(4),
                    $urandom_range(6));
      else if ($urandom_range(99) < 3)
        send_create($urandom_range(1023), $urandom, $urandom, $urandom);
      else send_tick();
    end
  endtask

  // Run ticks toward an empty table, with no idling at all.
  task automatic test_drain_table();
    no_idle = 1'b1;
    for (int k = 0; k < 150; k++) send_tick();
    no_idle = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_used[i] = 1'b0;
      sh_blocked[i] = 1'b0;
      sh_prio[i] = '0;
      sh_need[i] = '0;
      sh_spent[i] = '0;
      sh_burst_rl[i] = '0;
      sh_burst[i] = '0;
      sh_block_rl[i] = '0;
      sh_block[i] = '0;
    end
    sh_cur_valid = 1'b0;
    sh_cur = 0;
    sh_aging = 4'd1;
    sh_penalty = 4'd3;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_mix(250);
    write_reg(REG_AGING_STEP, 4'd15);
    write_reg(REG_RUN_PENALTY, 4'd0);
    test_random_mix(250);
    write_reg(REG_AGING_STEP, 4'd0);
    write_reg(REG_RUN_PENALTY, 4'd15);
    test_random_mix(250);
    test_drain_table();
    write_reg(REG_AGING_STEP, 4'd7);
    write_reg(REG_RUN_PENALTY, 4'd9);
    test_random_mix(230);
    drain();

    $display("covered %0d creates and %0d ticks, %0d results checked",
             creates_sent, ticks_sent, results_seen);
    $display("register settings swept: reset, aging 15/penalty 0, 0/15, 7/9");
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
